// ===== hdl/ipbm_pkg.sv =====
`default_nettype none

package ipbm_pkg;

   // Field and counter widths
   localparam int IDLE_WIDTH  = 24;
   localparam int LIGHT_BITS  = 12;
   localparam int TIMEOUT_W   = 24;
   localparam int INTERVAL_W  = 16;
   localparam int LEVEL_W     = 8;
   localparam int PRESS_W     = 16;
   localparam int ELAPSED_W   = 8;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   // Compare widths cover both operands
   localparam int CMP_W       = (IDLE_WIDTH > TIMEOUT_W) ? IDLE_WIDTH : TIMEOUT_W;
   localparam int LIGHT_CMP_W = (LIGHT_BITS > 12) ? LIGHT_BITS : 12;

   // Light mapping: clamp to LIGHT_LO..LIGHT_HI, scale by 255/3900 = 17/260
   localparam int LIGHT_LO    = 100;
   localparam int LIGHT_HI    = 4000;
   localparam int FULL_LEVEL  = 255;
   localparam int OFFSET_W    = 12;
   localparam int SCALED_W    = 17;
   localparam int LIGHT_NUM   = 17;
   localparam int LIGHT_DEN   = 260;
   localparam int LEVEL_DEN   = 255;
   localparam int RECIP_SHIFT = 24;
   localparam int RECIP_W     = 17;
   localparam int RECIP_LIGHT = (1 << RECIP_SHIFT) / LIGHT_DEN;
   localparam int RECIP_LEVEL = (1 << RECIP_SHIFT) / LEVEL_DEN;
   localparam int QUOT_W      = 9;
   localparam int SPAN_PROD_W = 2 * LEVEL_W;
   localparam int PROD1_W     = SCALED_W + RECIP_W;
   localparam int PROD2_W     = SPAN_PROD_W + RECIP_W;

   // Reset values of the configuration registers
   localparam int RST_IDLE_TIMEOUT  = 30000;
   localparam int RST_SLEEP_TIMEOUT = 300000;
   localparam int RST_CPU_DOWN      = 30000;
   localparam int RST_SLEEP_DELAY   = 120000;
   localparam int RST_INTERVAL      = 1000;
   localparam int RST_AUTO_MIN      = 10;
   localparam int RST_AUTO_MAX      = 255;

   typedef logic [IDLE_WIDTH-1:0]  idle_type;
   typedef logic [IDLE_WIDTH:0]    idle_sum_type;
   typedef logic [INTERVAL_W-1:0]  adjust_type;
   typedef logic [INTERVAL_W:0]    adjust_sum_type;
   typedef logic [TIMEOUT_W-1:0]   timeout_type;
   typedef logic [CMP_W-1:0]       cmp_type;
   typedef logic [LIGHT_CMP_W-1:0] light_cmp_type;
   typedef logic [OFFSET_W-1:0]    offset_type;
   typedef logic [SCALED_W-1:0]    scaled_type;
   typedef logic [PROD1_W-1:0]     prod1_type;
   typedef logic [PROD2_W-1:0]     prod2_type;
   typedef logic [SPAN_PROD_W-1:0] span_prod_type;
   typedef logic [QUOT_W-1:0]      quot_type;
   typedef logic [LEVEL_W-1:0]     level_type;
   typedef logic [PRESS_W-1:0]     press_type;

   typedef enum logic [1:0] {
      PWR_ACTIVE = 2'd0,
      PWR_IDLE   = 2'd1,
      PWR_SLEEP  = 2'd2
   } power_state_type;

   typedef enum logic [1:0] {
      BL_MANUAL = 2'd0,
      BL_AUTO   = 2'd1,
      BL_OFF    = 2'd2
   } bl_mode_type;

   typedef enum logic [1:0] {
      CPU_HIGH     = 2'd0,
      CPU_BALANCED = 2'd1,
      CPU_LOW      = 2'd2
   } cpu_mode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IDLE_TIMEOUT  = 3'd0,
      CSR_SLEEP_TIMEOUT = 3'd1,
      CSR_CPU_DOWN      = 3'd2,
      CSR_SLEEP_DELAY   = 3'd3,
      CSR_INTERVAL      = 3'd4,
      CSR_AUTO_MIN      = 3'd5,
      CSR_AUTO_MAX      = 3'd6
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'd0,
      ST_CLAMP  = 3'd1,
      ST_RECIP1 = 3'd2,
      ST_NORM   = 3'd3,
      ST_SCALE  = 3'd4,
      ST_RECIP2 = 3'd5,
      ST_LEVEL  = 3'd6,
      ST_COMMIT = 3'd7
   } ctrl_state_type;

   typedef struct packed {
      logic [ELAPSED_W-1:0]  elapsed_ms;
      logic                  touch_activity;
      logic                  button_press;
      logic [LIGHT_BITS-1:0] light_sample;
   } req_word_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] backlight_level;
      logic [1:0]         backlight_mode_out;
      logic [1:0]         power_state_out;
      logic [1:0]         cpu_mode_out;
      logic [PRESS_W-1:0] press_total;
   } rsp_word_type;

   typedef struct packed {
      logic capture;
      logic clamp;
      logic recip1;
      logic norm;
      logic scale;
      logic recip2;
      logic level;
      logic commit;
   } dp_cmd_type;

   typedef struct packed {
      logic out_busy;
   } dp_status_type;

endpackage

`default_nettype wire

// ===== hdl/ipbm_ctrl.sv =====
`default_nettype none

module ipbm_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire ipbm_pkg::dp_status_type status,
   output ipbm_pkg::dp_cmd_type        cmd
);

   ipbm_pkg::ctrl_state_type state_ff;
   ipbm_pkg::ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ipbm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ipbm_pkg::ST_IDLE: begin
            if (req_valid) state_in = ipbm_pkg::ST_CLAMP;
         end
         ipbm_pkg::ST_CLAMP:  state_in = ipbm_pkg::ST_RECIP1;
         ipbm_pkg::ST_RECIP1: state_in = ipbm_pkg::ST_NORM;
         ipbm_pkg::ST_NORM:   state_in = ipbm_pkg::ST_SCALE;
         ipbm_pkg::ST_SCALE:  state_in = ipbm_pkg::ST_RECIP2;
         ipbm_pkg::ST_RECIP2: state_in = ipbm_pkg::ST_LEVEL;
         ipbm_pkg::ST_LEVEL:  state_in = ipbm_pkg::ST_COMMIT;
         ipbm_pkg::ST_COMMIT: begin
            if (!status.out_busy) state_in = ipbm_pkg::ST_IDLE;
         end
         default: state_in = ipbm_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = (state_ff != ipbm_pkg::ST_IDLE);
      case (state_ff)
         ipbm_pkg::ST_IDLE:   cmd.capture = req_valid;
         ipbm_pkg::ST_CLAMP:  cmd.clamp   = 1'b1;
         ipbm_pkg::ST_RECIP1: cmd.recip1  = 1'b1;
         ipbm_pkg::ST_NORM:   cmd.norm    = 1'b1;
         ipbm_pkg::ST_SCALE:  cmd.scale   = 1'b1;
         ipbm_pkg::ST_RECIP2: cmd.recip2  = 1'b1;
         ipbm_pkg::ST_LEVEL:  cmd.level   = 1'b1;
         ipbm_pkg::ST_COMMIT: cmd.commit  = !status.out_busy;
         default: cmd = '0;
      endcase
   end

endmodule

`default_nettype wire

// ===== hdl/ipbm_datapath.sv =====
`default_nettype none

module ipbm_datapath (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire ipbm_pkg::dp_cmd_type                 cmd,
   output ipbm_pkg::dp_status_type                   status,
   input  wire ipbm_pkg::req_word_type               req_word,
   input  wire logic                                 csr_valid,
   input  wire logic [ipbm_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [ipbm_pkg::CSR_DATA_W-1:0]      csr_data,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output ipbm_pkg::rsp_word_type                    rsp_word
);

   // Configuration registers
   ipbm_pkg::timeout_type idle_timeout_ff, sleep_timeout_ff, cpu_down_ff, sleep_delay_ff;
   ipbm_pkg::adjust_type  interval_ff;
   ipbm_pkg::level_type   auto_min_ff, auto_max_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         idle_timeout_ff  <= ipbm_pkg::timeout_type'(ipbm_pkg::RST_IDLE_TIMEOUT);
         sleep_timeout_ff <= ipbm_pkg::timeout_type'(ipbm_pkg::RST_SLEEP_TIMEOUT);
         cpu_down_ff      <= ipbm_pkg::timeout_type'(ipbm_pkg::RST_CPU_DOWN);
         sleep_delay_ff   <= ipbm_pkg::timeout_type'(ipbm_pkg::RST_SLEEP_DELAY);
         interval_ff      <= ipbm_pkg::adjust_type'(ipbm_pkg::RST_INTERVAL);
         auto_min_ff      <= ipbm_pkg::level_type'(ipbm_pkg::RST_AUTO_MIN);
         auto_max_ff      <= ipbm_pkg::level_type'(ipbm_pkg::RST_AUTO_MAX);
      end else if (csr_valid) begin
         case (csr_index)
            ipbm_pkg::CSR_IDLE_TIMEOUT:  idle_timeout_ff  <= csr_data;
            ipbm_pkg::CSR_SLEEP_TIMEOUT: sleep_timeout_ff <= csr_data;
            ipbm_pkg::CSR_CPU_DOWN:      cpu_down_ff      <= csr_data;
            ipbm_pkg::CSR_SLEEP_DELAY:   sleep_delay_ff   <= csr_data;
            ipbm_pkg::CSR_INTERVAL:      interval_ff      <= csr_data[ipbm_pkg::INTERVAL_W-1:0];
            ipbm_pkg::CSR_AUTO_MIN:      auto_min_ff      <= csr_data[ipbm_pkg::LEVEL_W-1:0];
            ipbm_pkg::CSR_AUTO_MAX:      auto_max_ff      <= csr_data[ipbm_pkg::LEVEL_W-1:0];
            default: ;
         endcase
      end
   end

   // Captured word and mapping pipeline registers
   ipbm_pkg::req_word_type  word_ff;
   ipbm_pkg::idle_type      idle_pre_ff;
   ipbm_pkg::adjust_type    adjust_pre_ff;
   ipbm_pkg::scaled_type    scaled_ff;
   ipbm_pkg::prod1_type     prod1_ff;
   ipbm_pkg::level_type     norm_ff;
   ipbm_pkg::span_prod_type span_prod_ff;
   ipbm_pkg::prod2_type     prod2_ff;
   ipbm_pkg::level_type     map_level_ff;

   // Architectural state
   ipbm_pkg::idle_type        idle_count_ff, idle_count_in;
   ipbm_pkg::adjust_type      adjust_count_ff, adjust_count_in;
   ipbm_pkg::power_state_type power_state_ff, power_state_in;
   ipbm_pkg::cpu_mode_type    cpu_mode_ff, cpu_mode_in;
   ipbm_pkg::bl_mode_type     bl_mode_ff, bl_mode_in;
   ipbm_pkg::level_type       level_now_ff, level_now_in;
   ipbm_pkg::level_type       manual_level_ff, manual_level_in;
   ipbm_pkg::press_type       press_count_ff, press_count_in;

   logic                  rsp_valid_ff;
   ipbm_pkg::rsp_word_type rsp_word_ff, rsp_word_in;

   // Counter advance and light clamp
   ipbm_pkg::idle_sum_type   idle_sum;
   ipbm_pkg::adjust_sum_type adjust_sum;
   ipbm_pkg::light_cmp_type  light_ext, light_clamped;
   ipbm_pkg::offset_type     light_offset;

   always_comb begin
      idle_sum   = ipbm_pkg::idle_sum_type'(idle_count_ff) +
                   ipbm_pkg::idle_sum_type'(word_ff.elapsed_ms);
      adjust_sum = ipbm_pkg::adjust_sum_type'(adjust_count_ff) +
                   ipbm_pkg::adjust_sum_type'(word_ff.elapsed_ms);
      light_ext  = ipbm_pkg::light_cmp_type'(word_ff.light_sample);
      if (light_ext < ipbm_pkg::light_cmp_type'(ipbm_pkg::LIGHT_LO)) begin
         light_clamped = ipbm_pkg::light_cmp_type'(ipbm_pkg::LIGHT_LO);
      end else if (light_ext > ipbm_pkg::light_cmp_type'(ipbm_pkg::LIGHT_HI)) begin
         light_clamped = ipbm_pkg::light_cmp_type'(ipbm_pkg::LIGHT_HI);
      end else begin
         light_clamped = light_ext;
      end
      light_offset = ipbm_pkg::offset_type'(light_clamped -
                     ipbm_pkg::light_cmp_type'(ipbm_pkg::LIGHT_LO));
   end

   // Divide by 260 and 255 through reciprocal products with one correction step
   ipbm_pkg::quot_type   norm_q0, span_q0;
   ipbm_pkg::scaled_type norm_rem;
   ipbm_pkg::span_prod_type span_rem;
   ipbm_pkg::quot_type   norm_q, span_q;
   logic                 span_neg;
   ipbm_pkg::level_type  span_mag;

   always_comb begin
      norm_q0  = prod1_ff[ipbm_pkg::RECIP_SHIFT +: ipbm_pkg::QUOT_W];
      norm_rem = scaled_ff - ipbm_pkg::scaled_type'(norm_q0) *
                 ipbm_pkg::scaled_type'(ipbm_pkg::LIGHT_DEN);
      norm_q   = (norm_rem >= ipbm_pkg::scaled_type'(ipbm_pkg::LIGHT_DEN)) ?
                 norm_q0 + ipbm_pkg::quot_type'(1) : norm_q0;
      span_neg = (auto_max_ff < auto_min_ff);
      span_mag = span_neg ? auto_min_ff - auto_max_ff : auto_max_ff - auto_min_ff;
      span_q0  = prod2_ff[ipbm_pkg::RECIP_SHIFT +: ipbm_pkg::QUOT_W];
      span_rem = span_prod_ff - ipbm_pkg::span_prod_type'(span_q0) *
                 ipbm_pkg::span_prod_type'(ipbm_pkg::LEVEL_DEN);
      span_q   = (span_rem >= ipbm_pkg::span_prod_type'(ipbm_pkg::LEVEL_DEN)) ?
                 span_q0 + ipbm_pkg::quot_type'(1) : span_q0;
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) word_ff <= req_word;
      if (cmd.clamp) begin
         idle_pre_ff   <= word_ff.touch_activity ? '0 :
                          (idle_sum[ipbm_pkg::IDLE_WIDTH] ? '1 :
                           idle_sum[ipbm_pkg::IDLE_WIDTH-1:0]);
         adjust_pre_ff <= adjust_sum[ipbm_pkg::INTERVAL_W] ? '1 :
                          adjust_sum[ipbm_pkg::INTERVAL_W-1:0];
         scaled_ff     <= ipbm_pkg::scaled_type'(light_offset) *
                          ipbm_pkg::scaled_type'(ipbm_pkg::LIGHT_NUM);
      end
      if (cmd.recip1) begin
         prod1_ff <= ipbm_pkg::prod1_type'(scaled_ff) *
                     ipbm_pkg::prod1_type'(ipbm_pkg::RECIP_LIGHT);
      end
      if (cmd.norm) norm_ff <= norm_q[ipbm_pkg::LEVEL_W-1:0];
      if (cmd.scale) begin
         span_prod_ff <= ipbm_pkg::span_prod_type'(norm_ff) *
                         ipbm_pkg::span_prod_type'(span_mag);
      end
      if (cmd.recip2) begin
         prod2_ff <= ipbm_pkg::prod2_type'(span_prod_ff) *
                     ipbm_pkg::prod2_type'(ipbm_pkg::RECIP_LEVEL);
      end
      if (cmd.level) begin
         map_level_ff <= span_neg ? auto_min_ff - span_q[ipbm_pkg::LEVEL_W-1:0] :
                                    auto_min_ff + span_q[ipbm_pkg::LEVEL_W-1:0];
      end
   end

   // Threshold compares; a press clears the idle time first
   ipbm_pkg::cmp_type idle_ext;
   logic reach_idle_pre, reach_idle, reach_sleep, reach_delay, reach_cpu, adjust_due;

   always_comb begin
      idle_ext       = ipbm_pkg::cmp_type'(idle_pre_ff);
      reach_idle_pre = idle_ext >= ipbm_pkg::cmp_type'(idle_timeout_ff);
      if (word_ff.button_press) begin
         reach_idle  = (idle_timeout_ff == '0);
         reach_sleep = (sleep_timeout_ff == '0);
         reach_delay = (sleep_delay_ff == '0);
         reach_cpu   = (cpu_down_ff == '0);
      end else begin
         reach_idle  = reach_idle_pre;
         reach_sleep = idle_ext >= ipbm_pkg::cmp_type'(sleep_timeout_ff);
         reach_delay = idle_ext >= ipbm_pkg::cmp_type'(sleep_delay_ff);
         reach_cpu   = idle_ext >= ipbm_pkg::cmp_type'(cpu_down_ff);
      end
      adjust_due = (adjust_pre_ff >= interval_ff);
   end

   always_comb begin
      idle_count_in   = idle_pre_ff;
      adjust_count_in = adjust_pre_ff;
      power_state_in  = power_state_ff;
      cpu_mode_in     = cpu_mode_ff;
      bl_mode_in      = bl_mode_ff;
      level_now_in    = level_now_ff;
      manual_level_in = manual_level_ff;
      press_count_in  = press_count_ff;
      if (power_state_ff == ipbm_pkg::PWR_SLEEP) begin
         // Only a press acts: count it and wake, mode untouched
         if (word_ff.button_press) begin
            press_count_in = press_count_ff + ipbm_pkg::press_type'(1);
            power_state_in = ipbm_pkg::PWR_ACTIVE;
            cpu_mode_in    = ipbm_pkg::CPU_HIGH;
            idle_count_in  = '0;
            if (bl_mode_ff == ipbm_pkg::BL_MANUAL) level_now_in = manual_level_ff;
         end
      end else begin
         if (word_ff.button_press) begin
            press_count_in = press_count_ff + ipbm_pkg::press_type'(1);
            case (bl_mode_ff)
               ipbm_pkg::BL_MANUAL: begin
                  bl_mode_in = ipbm_pkg::BL_AUTO;
                  if (reach_idle_pre) level_now_in = map_level_ff;
               end
               ipbm_pkg::BL_AUTO: begin
                  bl_mode_in   = ipbm_pkg::BL_OFF;
                  level_now_in = '0;
               end
               default: begin
                  bl_mode_in      = ipbm_pkg::BL_MANUAL;
                  manual_level_in = ipbm_pkg::level_type'(ipbm_pkg::FULL_LEVEL);
                  level_now_in    = ipbm_pkg::level_type'(ipbm_pkg::FULL_LEVEL);
               end
            endcase
            idle_count_in = '0;
         end
         if (bl_mode_in == ipbm_pkg::BL_AUTO && adjust_due) begin
            adjust_count_in = '0;
            if (reach_idle) level_now_in = map_level_ff;
         end
         if (reach_sleep) begin
            power_state_in = ipbm_pkg::PWR_SLEEP;
            level_now_in   = '0;
         end else if (reach_delay && bl_mode_in == ipbm_pkg::BL_OFF) begin
            power_state_in = ipbm_pkg::PWR_SLEEP;
            level_now_in   = '0;
         end else if (reach_cpu && bl_mode_in == ipbm_pkg::BL_OFF) begin
            cpu_mode_in = ipbm_pkg::CPU_BALANCED;
         end else if (reach_idle && power_state_ff == ipbm_pkg::PWR_ACTIVE) begin
            power_state_in = ipbm_pkg::PWR_IDLE;
         end else if (!reach_idle && power_state_ff == ipbm_pkg::PWR_IDLE) begin
            power_state_in = ipbm_pkg::PWR_ACTIVE;
         end
      end
      rsp_word_in.backlight_level    = level_now_in;
      rsp_word_in.backlight_mode_out = bl_mode_in;
      rsp_word_in.power_state_out    = power_state_in;
      rsp_word_in.cpu_mode_out       = cpu_mode_in;
      rsp_word_in.press_total        = press_count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idle_count_ff   <= '0;
         adjust_count_ff <= '0;
         power_state_ff  <= ipbm_pkg::PWR_ACTIVE;
         cpu_mode_ff     <= ipbm_pkg::CPU_HIGH;
         bl_mode_ff      <= ipbm_pkg::BL_MANUAL;
         level_now_ff    <= ipbm_pkg::level_type'(ipbm_pkg::FULL_LEVEL);
         manual_level_ff <= ipbm_pkg::level_type'(ipbm_pkg::FULL_LEVEL);
         press_count_ff  <= '0;
      end else if (cmd.commit) begin
         idle_count_ff   <= idle_count_in;
         adjust_count_ff <= adjust_count_in;
         power_state_ff  <= power_state_in;
         cpu_mode_ff     <= cpu_mode_in;
         bl_mode_ff      <= bl_mode_in;
         level_now_ff    <= level_now_in;
         manual_level_ff <= manual_level_in;
         press_count_ff  <= press_count_in;
      end
   end

   // Output word register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.commit) rsp_word_ff <= rsp_word_in;
   end

   assign status.out_busy = rsp_valid_ff & rsp_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_word        = rsp_word_ff;

endmodule

`default_nettype wire

// ===== hdl/idle_power_and_backlight_manager_core.sv =====
// Idle power and backlight manager.
// Request channel (req_valid / req_stall / req_word): one word per time tick with
// the elapsed milliseconds, touch and button flags and a light-sensor sample.
// Response channel (rsp_valid / rsp_stall / rsp_word): one word per request with
// the backlight level and mode, power state, CPU mode and press count.
// Register port (csr_valid / csr_ready / csr_index / csr_data): csr_ready is
// always high; write only while no request is in flight.
// The sequencer walks the light-to-level mapping (clamp, two reciprocal
// multiplies with correction, level offset) and the state update through one
// shared datapath, one word at a time: no new request is taken until the last
// one is committed.
// A held response does not block intake: the next request is taken and mapped,
// and its update waits in the final step until the output register frees up.
// Reset (synchronous, active high) returns the registers to their defaults, the
// state to active, CPU high, manual mode at full level, counters at zero.
`default_nettype none

module idle_power_and_backlight_manager_core (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire ipbm_pkg::req_word_type           req_word,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output ipbm_pkg::rsp_word_type                rsp_word,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [ipbm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [ipbm_pkg::CSR_DATA_W-1:0]  csr_data
);

   ipbm_pkg::dp_cmd_type    cmd;
   ipbm_pkg::dp_status_type status;

   // Registers accept every write
   assign csr_ready = 1'b1;

   // Sequencer: one word at a time through the mapping steps
   ipbm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Registers, mapping arithmetic, state and output word
   ipbm_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_word  (req_word),
      .csr_valid (csr_valid & csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

endmodule

`default_nettype wire

// ===== hdl/ipbm_checker.sv =====
`default_nettype none

module ipbm_checker (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_valid,
   input wire logic                   req_stall,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_stall,
   input wire ipbm_pkg::rsp_word_type rsp_word
);

   // Held response word stays put
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("response word changed while stalled");

   // One word at a time: intake closes after a request is taken
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while previous word in flight");

   // Sleep drives the backlight dark
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.power_state_out == ipbm_pkg::PWR_SLEEP
      |-> rsp_word.backlight_level == '0)
      else $error("backlight lit while sleeping");

   // Mode off drives the backlight dark
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.backlight_mode_out == ipbm_pkg::BL_OFF
      |-> rsp_word.backlight_level == '0)
      else $error("backlight lit in off mode");

endmodule

bind idle_power_and_backlight_manager_core ipbm_checker u_ipbm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word)
);

`default_nettype wire

// ===== tb/idle_power_and_backlight_manager_core_tb.sv =====
`timescale 1ns / 100ps

module idle_power_and_backlight_manager_core_tb;
   import ipbm_pkg::*;

   localparam int RSP_LATENCY  = 7;
   localparam int CYCLE_LIMIT  = 200_000;
   localparam int HOLD_CYCLES  = 600;
   localparam int SOAK_WORDS   = 260;
   localparam int REPORT_LINES = 60;

   // Index past the end of the register list: the block must ignore it.
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 3'd7;

   typedef enum logic [1:0] {
      ROW_PREDICT = 2'd0,
      ROW_KNOWN   = 2'd1,
      ROW_CSR     = 2'd2
   } row_kind_type;

   typedef struct packed {
      row_kind_type             kind;
      logic [CSR_INDEX_W-1:0]   csr_idx;
      logic [CSR_DATA_W-1:0]    csr_val;
      req_word_type             word;
      rsp_word_type             known;
   } script_row_type;

   // Drive every input to a known value from time zero.
   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_word_type           req_word  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_word_type           rsp_word;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data  = '0;

   // Idling knobs and pressure flag.
   int   send_idle_pct = 0;
   int   stall_pct     = 0;
   logic hold_rsp      = 1'b0;

   // Bookkeeping.
   int   cycle_count    = 0;
   int   err_count      = 0;
   int   words_sent     = 0;
   int   checked_count  = 0;
   int   settings_count = 0;
   logic csr_open       = 1'b0;

   rsp_word_type   expected_rsp[$];
   script_row_type script[$];

   // Predictor copy of the configuration registers.
   timeout_type cfg_idle_to, cfg_sleep_to, cfg_cpu_down, cfg_sleep_delay;
   adjust_type  cfg_interval;
   level_type   cfg_min, cfg_max;

   // Predictor copy of the block state.
   idle_type        idle_ms;
   adjust_type      adjust_ms;
   power_state_type pwr;
   cpu_mode_type    cpu;
   bl_mode_type     bl;
   level_type       level_now, manual_level;
   press_type       presses;

   idle_power_and_backlight_manager_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog: end the run if it hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   // Put the state and registers back to their power-on values.
   task automatic reset_model();
      cfg_idle_to     = timeout_type'(RST_IDLE_TIMEOUT);
      cfg_sleep_to    = timeout_type'(RST_SLEEP_TIMEOUT);
      cfg_cpu_down    = timeout_type'(RST_CPU_DOWN);
      cfg_sleep_delay = timeout_type'(RST_SLEEP_DELAY);
      cfg_interval    = adjust_type'(RST_INTERVAL);
      cfg_min         = level_type'(RST_AUTO_MIN);
      cfg_max         = level_type'(RST_AUTO_MAX);
      idle_ms         = '0;
      adjust_ms       = '0;
      pwr             = PWR_ACTIVE;
      cpu             = CPU_HIGH;
      bl              = BL_MANUAL;
      level_now       = level_type'(FULL_LEVEL);
      manual_level    = level_type'(FULL_LEVEL);
      presses         = '0;
   endtask

   // Mirror a register write, masking the value to the register's width.
   task automatic apply_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] val);
      case (idx)
         CSR_IDLE_TIMEOUT:  cfg_idle_to     = val;
         CSR_SLEEP_TIMEOUT: cfg_sleep_to    = val;
         CSR_CPU_DOWN:      cfg_cpu_down    = val;
         CSR_SLEEP_DELAY:   cfg_sleep_delay = val;
         CSR_INTERVAL:      cfg_interval    = val[INTERVAL_W-1:0];
         CSR_AUTO_MIN:      cfg_min         = val[LEVEL_W-1:0];
         CSR_AUTO_MAX:      cfg_max         = val[LEVEL_W-1:0];
         default: ;
      endcase
   endtask

   // Clamp the light sample, scale to 0..255, then onto min..max. Signed
   // division truncates toward zero, which gives the falling map when the
   // minimum sits above the maximum.
   function automatic level_type light_level(input logic [LIGHT_BITS-1:0] sample);
      int v, n, lo, hi;
      v  = int'(sample);
      lo = int'(cfg_min);
      hi = int'(cfg_max);
      if (v < LIGHT_LO) v = LIGHT_LO;
      if (v > LIGHT_HI) v = LIGHT_HI;
      n = ((v - LIGHT_LO) * FULL_LEVEL) / (LIGHT_HI - LIGHT_LO);
      return level_type'(lo + (n * (hi - lo)) / FULL_LEVEL);
   endfunction

   // Advance the state by one request word and form the response word.
   task automatic predict_word(input req_word_type w, output rsp_word_type r);
      int unsigned  adj_sum;
      idle_sum_type idle_sum;
      adj_sum   = 32'(adjust_ms) + 32'(w.elapsed_ms);
      adjust_ms = (adj_sum > 32'hFFFF) ? '1 : adjust_type'(adj_sum);
      if (w.touch_activity) begin
         idle_ms = '0;
      end else begin
         idle_sum = idle_sum_type'(idle_ms) + idle_sum_type'(w.elapsed_ms);
         idle_ms  = idle_sum[IDLE_WIDTH] ? '1 : idle_sum[IDLE_WIDTH-1:0];
      end

      if (pwr == PWR_SLEEP) begin
         // Asleep: only the button acts. Wake without cycling the mode.
         if (w.button_press) begin
            presses = presses + press_type'(1);
            pwr     = PWR_ACTIVE;
            cpu     = CPU_HIGH;
            idle_ms = '0;
            if (bl == BL_MANUAL) level_now = manual_level;
         end
      end else begin
         if (w.button_press) begin
            presses = presses + press_type'(1);
            case (bl)
               BL_MANUAL: begin
                  bl = BL_AUTO;
                  if (idle_ms >= cfg_idle_to) level_now = light_level(w.light_sample);
               end
               BL_AUTO: begin
                  bl        = BL_OFF;
                  level_now = '0;
               end
               default: begin
                  bl           = BL_MANUAL;
                  manual_level = level_type'(FULL_LEVEL);
                  level_now    = manual_level;
               end
            endcase
            idle_ms = '0;
         end

         if (bl == BL_AUTO && adjust_ms >= cfg_interval) begin
            adjust_ms = '0;
            if (idle_ms >= cfg_idle_to) level_now = light_level(w.light_sample);
         end

         // Timeout ladder, first match wins.
         if (idle_ms >= cfg_sleep_to) begin
            pwr       = PWR_SLEEP;
            level_now = '0;
         end else if (idle_ms >= cfg_sleep_delay && bl == BL_OFF) begin
            pwr       = PWR_SLEEP;
            level_now = '0;
         end else if (idle_ms >= cfg_cpu_down && bl == BL_OFF) begin
            cpu = CPU_BALANCED;
         end else if (idle_ms >= cfg_idle_to && pwr == PWR_ACTIVE) begin
            pwr = PWR_IDLE;
         end else if (idle_ms < cfg_idle_to && pwr == PWR_IDLE) begin
            pwr = PWR_ACTIVE;
         end
      end

      r.backlight_level    = level_now;
      r.backlight_mode_out = bl;
      r.power_state_out    = pwr;
      r.cpu_mode_out       = cpu;
      r.press_total        = presses;
   endtask

   // ---------------------------------------------------------------------
   // Response side: check each accepted word, stall at random or on hold
   // ---------------------------------------------------------------------

   task automatic report(input string msg);
      err_count++;
      if (err_count <= REPORT_LINES) $display("ERROR: %s", msg);
   endtask

   task automatic compare_field(input string name, input int got, input int want);
      if (got !== want)
         report($sformatf("response %0d: %s is %0d, expected %0d",
                          checked_count, name, got, want));
   endtask

   task automatic check_word(input rsp_word_type got);
      rsp_word_type want;
      if (expected_rsp.size() == 0) begin
         report($sformatf("response %h arrived with nothing outstanding", got));
      end else begin
         want = expected_rsp.pop_front();
         checked_count++;
         compare_field("backlight_level", int'(got.backlight_level),
                       int'(want.backlight_level));
         compare_field("backlight_mode_out", int'(got.backlight_mode_out),
                       int'(want.backlight_mode_out));
         compare_field("power_state_out", int'(got.power_state_out),
                       int'(want.power_state_out));
         compare_field("cpu_mode_out", int'(got.cpu_mode_out), int'(want.cpu_mode_out));
         compare_field("press_total", int'(got.press_total), int'(want.press_total));
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) check_word(rsp_word);
      // Hold the response channel during a pressure stretch, else stall at random.
      if (hold_rsp) begin
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99, 0) < stall_pct);
      end
   end

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------

   // Offer one word after a random gap, hold it until taken, then record
   // its expected response (typed-in value for the known rows).
   task automatic send_word(input req_word_type w, input logic use_known,
                            input rsp_word_type known);
      rsp_word_type pred;
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_word(w, pred);
      expected_rsp.push_back(use_known ? known : pred);
      words_sent++;
   endtask

   // Drop valid and wait until every outstanding response has come back.
   task automatic drain_words();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_rsp.size() != 0);
   endtask

   // Write one register; leave csr_valid up so back-to-back writes do not
   // toggle it within one step.
   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      apply_register(idx, val);
   endtask

   // Load a full register setting with the block idle.
   task automatic load_settings(input logic [CSR_DATA_W-1:0] idle_to, sleep_to,
                                cpu_down, sleep_delay, interval, lvl_min, lvl_max);
      drain_words();
      write_register(CSR_IDLE_TIMEOUT, idle_to);
      write_register(CSR_SLEEP_TIMEOUT, sleep_to);
      write_register(CSR_CPU_DOWN, cpu_down);
      write_register(CSR_SLEEP_DELAY, sleep_delay);
      write_register(CSR_INTERVAL, interval);
      write_register(CSR_AUTO_MIN, lvl_min);
      write_register(CSR_AUTO_MAX, lvl_max);
      csr_valid <= 1'b0;
      settings_count++;
   endtask

   // Random word: elapsed and light lean toward their extremes and the
   // clamp edges; touch and press rates set how deep the timeouts go.
   function automatic req_word_type random_word(input int touch_pct, input int press_pct);
      req_word_type w;
      int           pick;
      pick = $urandom_range(99, 0);
      if (pick < 10)      w.elapsed_ms = '0;
      else if (pick < 25) w.elapsed_ms = '1;
      else                w.elapsed_ms = ELAPSED_W'($urandom);
      w.touch_activity = ($urandom_range(99, 0) < touch_pct);
      w.button_press   = ($urandom_range(99, 0) < press_pct);
      pick = $urandom_range(99, 0);
      if (pick < 12)      w.light_sample = '0;
      else if (pick < 24) w.light_sample = '1;
      else if (pick < 34) w.light_sample = LIGHT_BITS'(LIGHT_LO - 2 + $urandom_range(4, 0));
      else if (pick < 44) w.light_sample = LIGHT_BITS'(LIGHT_HI - 2 + $urandom_range(4, 0));
      else                w.light_sample = LIGHT_BITS'($urandom);
      return w;
   endfunction

   task automatic run_random(input int count, input int touch_pct, input int press_pct,
                             input int idle_pct, input int stall_rate);
      send_idle_pct = idle_pct;
      stall_pct    <= stall_rate;
      repeat (count) send_word(random_word(touch_pct, press_pct), 1'b0, '0);
   endtask

   // ---------------------------------------------------------------------
   // Directed table rows
   // ---------------------------------------------------------------------

   function automatic script_row_type item_row(input int e, t, p, l);
      script_row_type row;
      row                     = '0;
      row.kind                = ROW_PREDICT;
      row.word.elapsed_ms     = ELAPSED_W'(e);
      row.word.touch_activity = 1'(t);
      row.word.button_press   = 1'(p);
      row.word.light_sample   = LIGHT_BITS'(l);
      return row;
   endfunction

   function automatic script_row_type known_row(input int e, t, p, l, lvl,
                                                input bl_mode_type m,
                                                input power_state_type ps,
                                                input cpu_mode_type c, input int n);
      script_row_type row;
      row                          = item_row(e, t, p, l);
      row.kind                     = ROW_KNOWN;
      row.known.backlight_level    = LEVEL_W'(lvl);
      row.known.backlight_mode_out = m;
      row.known.power_state_out    = ps;
      row.known.cpu_mode_out       = c;
      row.known.press_total        = PRESS_W'(n);
      return row;
   endfunction

   function automatic script_row_type csr_row(input logic [CSR_INDEX_W-1:0] idx,
                                              input logic [CSR_DATA_W-1:0] val);
      script_row_type row;
      row         = '0;
      row.kind    = ROW_CSR;
      row.csr_idx = idx;
      row.csr_val = val;
      return row;
   endfunction

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      // Defaults after reset: cycle the mode once round with the button.
      script.push_back(known_row(0, 0, 0, 0, 255, BL_MANUAL, PWR_ACTIVE, CPU_HIGH, 0));
      script.push_back(known_row(255, 0, 1, 4095, 255, BL_AUTO, PWR_ACTIVE, CPU_HIGH, 1));
      script.push_back(known_row(255, 0, 1, 0, 0, BL_OFF, PWR_ACTIVE, CPU_HIGH, 2));
      script.push_back(known_row(255, 1, 1, 4095, 255, BL_MANUAL, PWR_ACTIVE, CPU_HIGH, 3));
      script.push_back(item_row(255, 1, 0, 2048));
      // Zero idle timeout and interval: auto entry maps at once, then every word.
      script.push_back(csr_row(CSR_IDLE_TIMEOUT, 24'd0));
      script.push_back(csr_row(CSR_INTERVAL, 24'd0));
      script.push_back(item_row(0, 0, 1, 4095));
      script.push_back(item_row(1, 0, 0, 0));
      script.push_back(item_row(7, 0, 0, LIGHT_LO));
      script.push_back(item_row(0, 0, 0, LIGHT_HI));
      script.push_back(item_row(128, 0, 0, 2050));
      // Minimum above maximum: falling map.
      script.push_back(csr_row(CSR_AUTO_MIN, 24'd255));
      script.push_back(csr_row(CSR_AUTO_MAX, 24'd0));
      script.push_back(item_row(0, 0, 0, 0));
      script.push_back(item_row(0, 1, 0, 4095));
      // Zero sleep timeout: sleep, ignore touch while asleep, wake on press,
      // and restore the manual level on wake.
      script.push_back(csr_row(CSR_SLEEP_TIMEOUT, 24'd0));
      script.push_back(item_row(3, 0, 0, 1000));
      script.push_back(item_row(255, 1, 0, 4095));
      script.push_back(item_row(0, 0, 1, 0));
      script.push_back(item_row(0, 0, 1, 0));
      script.push_back(item_row(0, 0, 1, 0));
      script.push_back(item_row(0, 0, 1, 0));
      script.push_back(item_row(0, 0, 1, 0));
      // Backlight off: CPU slows down, then the sleep delay takes over.
      script.push_back(csr_row(CSR_SLEEP_TIMEOUT, 24'hFFFFFF));
      script.push_back(csr_row(CSR_CPU_DOWN, 24'd0));
      script.push_back(csr_row(CSR_SLEEP_DELAY, 24'hFFFFFF));
      script.push_back(item_row(0, 0, 1, 3000));
      script.push_back(item_row(0, 0, 1, 3000));
      script.push_back(item_row(255, 0, 0, 4095));
      script.push_back(csr_row(CSR_SLEEP_DELAY, 24'd0));
      script.push_back(item_row(0, 0, 0, 0));
      script.push_back(item_row(0, 0, 1, 0));
      // Out-of-range index is ignored; wide data is masked to the register.
      script.push_back(csr_row(CSR_UNUSED, 24'h00ABCD));
      script.push_back(csr_row(CSR_INTERVAL, 24'hAB0064));

      reset_model();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Walk the directed table with no idling on either side.
      foreach (script[i]) begin
         if (script[i].kind == ROW_CSR) begin
            if (!csr_open) drain_words();
            write_register(script[i].csr_idx, script[i].csr_val);
            csr_open = 1'b1;
         end else begin
            if (csr_open) begin
               csr_valid <= 1'b0;
               csr_open   = 1'b0;
            end
            send_word(script[i].word, script[i].kind == ROW_KNOWN, script[i].known);
         end
      end
      if (csr_open) csr_valid <= 1'b0;
      settings_count++;

      // Soak: untouched 255 ms ticks with the longest interval until the
      // adjust counter tops out; the idle counter climbs far along the way.
      load_settings(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFF, 24'd0, 24'd255);
      send_idle_pct = 0;
      repeat (SOAK_WORDS) begin
         send_word({8'd255, 1'b0, 1'b0, LIGHT_BITS'($urandom)}, 1'b0, '0);
      end

      // Short timeouts, no idling.
      load_settings(24'd300, 24'd6000, 24'd600, 24'd1500, 24'd100, 24'd10, 24'd255);
      run_random(270, 3, 6, 0, 0);

      // Zero timeouts and interval, sender idle most cycles.
      load_settings(24'd0, 24'hFFFFFF, 24'd0, 24'd800, 24'd0, 24'd0, 24'd255);
      run_random(270, 5, 8, 81, 0);

      // Medium timeouts with masked writes and a write to the unused index;
      // receiver stalls most cycles.
      load_settings(24'd1000, 24'd20000, 24'd2000, 24'd5000, 24'hFF01F4, 24'h1200C8,
                    24'h340028);
      @(posedge clock);
      write_register(CSR_UNUSED, 24'hFFFFFF);
      csr_valid <= 1'b0;
      run_random(300, 2, 5, 0, 81);

      // Falling map, longest interval, both sides idle a third of the time.
      load_settings(24'd50, 24'd3000, 24'd100, 24'd400, 24'hFFFF, 24'd255, 24'd0);
      run_random(300, 4, 6, 33, 33);

      // Reset values. Hold the receiver off for a long stretch while words
      // keep coming so the block backs up, then pause until all are back.
      load_settings(CSR_DATA_W'(RST_IDLE_TIMEOUT), CSR_DATA_W'(RST_SLEEP_TIMEOUT),
                    CSR_DATA_W'(RST_CPU_DOWN), CSR_DATA_W'(RST_SLEEP_DELAY),
                    CSR_DATA_W'(RST_INTERVAL), CSR_DATA_W'(RST_AUTO_MIN),
                    CSR_DATA_W'(RST_AUTO_MAX));
      fork
         begin
            hold_rsp <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp <= 1'b0;
         end
      join_none
      run_random(120, 1, 3, 0, 0);
      drain_words();
      run_random(200, 1, 3, 33, 33);

      // Wait for the last responses, then allow for any stray extra word.
      req_valid <= 1'b0;
      stall_pct <= 0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (4 * RSP_LATENCY) @(posedge clock);

      $display("Covered %0d request words (%0d in the adjust counter soak) over %0d settings,",
               words_sent, SOAK_WORDS, settings_count);
      $display("with %0d responses checked through sleep, wake, mode cycling and backpressure.",
               checked_count);
      if (err_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
